/* src/cicg_pkg.sv */
// ----------------------------------------------------------------------------
// cicg_pkg: shared types and constants for the count-in click generator
// Register indexes, reset values, the serial arithmetic unit's command and
// response structs, and the sine table entry function.
// ----------------------------------------------------------------------------
package cicg_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_BEAT_SAMPLES    = 3'd0;
   localparam logic [2:0] CSR_BAR_SAMPLES     = 3'd1;
   localparam logic [2:0] CSR_TOTAL_SAMPLES   = 3'd2;
   localparam logic [2:0] CSR_CLICK_GAIN      = 3'd3;
   localparam logic [2:0] CSR_LONG_CLICK_LEN  = 3'd4;
   localparam logic [2:0] CSR_SHORT_CLICK_LEN = 3'd5;
   localparam logic [2:0] CSR_HIGH_PHASE_STEP = 3'd6;
   localparam logic [2:0] CSR_LOW_PHASE_STEP  = 3'd7;

   localparam int CSR_DATA_W = 24;

   // register reset values
   localparam logic [19:0] BEAT_RST  = 20'd24000;
   localparam logic [23:0] BAR_RST   = 24'd96000;
   localparam logic [23:0] TOTAL_RST = 24'd96000;
   localparam logic [15:0] GAIN_RST  = 16'd32768;
   localparam logic [15:0] LONG_RST  = 16'd2880;
   localparam logic [15:0] SHORT_RST = 16'd1920;
   localparam logic [15:0] HSTEP_RST = 16'd2141;
   localparam logic [15:0] LSTEP_RST = 16'd1429;

   // Q1.15 amplitudes
   localparam logic [15:0] AMP_DOWN = 16'd16384;
   localparam logic [15:0] AMP_OFF  = 16'd10486;

   // serial unit step counts
   localparam logic [4:0] MUL_STEPS  = 5'd8;
   localparam logic [4:0] ENV_STEPS  = 5'd16;
   localparam logic [4:0] MOD1_STEPS = 5'd24;
   localparam logic [4:0] MOD2_STEPS = 5'd25;

   typedef enum logic [1:0] {
      OP_MUL = 2'b01,
      OP_DIV = 2'b10
   } op_type;

   typedef struct packed {
      logic        go;
      op_type      op;
      logic [24:0] num;
      logic [23:0] den;
      logic [23:0] rem_init;
      logic [4:0]  steps;
      logic [15:0] mcand;
      logic [15:0] mplier;
   } ser_cmd_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quot;
      logic [23:0] rem;
      logic [15:0] prod;
   } ser_rsp_type;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

   // one sine table entry; ang is the angle with 2^32 per turn
   function automatic logic signed [15:0] sine_q15(input logic [63:0] ang);
      logic [1:0]  quad;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      quad = ang[31:30];
      r    = {34'd0, ang[29:0]};
      if (quad[0]) begin
         r = Q30_ONE - r;
      end
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      v    = (sum * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      return quad[1] ? $signed(16'(64'd0 - v)) : $signed(v[15:0]);
   endfunction

endpackage

/* src/cicg_serial.sv */
// ----------------------------------------------------------------------------
// cicg_serial: shared bit-serial multiply and divide unit
// Multiply: 16x16, two multiplier bits per cycle, rounded Q15 result.
// Divide: restoring, one dividend bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module cicg_serial (
   input  logic                  clock,
   input  logic                  reset,
   input  cicg_pkg::ser_cmd_type cmd,
   output cicg_pkg::ser_rsp_type rsp
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic        mul_ff, mul_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] a_ff, a_in;
   logic [15:0] b_ff, b_in;
   logic [31:0] p_ff, p_in;
   logic [23:0] den_ff, den_in;
   logic [23:0] r_ff, r_in;
   logic [24:0] d_ff, d_in;
   logic [15:0] q_ff, q_in;

   logic [24:0] trial;
   logic [25:0] diff;
   logic        fits;
   logic [17:0] pp;
   logic [31:0] p_next;
   logic [32:0] p_rnd;

   assign trial  = {r_ff, d_ff[24]};
   assign diff   = {1'b0, trial} - {2'b00, den_ff};
   assign fits   = ~diff[25];
   assign pp     = ({2'b00, a_ff} & {18{b_ff[14]}}) + ({1'b0, a_ff, 1'b0} & {18{b_ff[15]}});
   assign p_next = {p_ff[29:0], 2'b00} + {14'd0, pp};
   assign p_rnd  = {1'b0, p_ff} + 33'd16384;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      mul_in  = mul_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      den_in  = den_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      if (cmd.go) begin
         run_in = 1'b1;
         mul_in = (cmd.op == cicg_pkg::OP_MUL);
         cnt_in = (cmd.op == cicg_pkg::OP_MUL) ? cicg_pkg::MUL_STEPS : cmd.steps;
         a_in   = cmd.mcand;
         b_in   = cmd.mplier;
         p_in   = '0;
         den_in = cmd.den;
         r_in   = cmd.rem_init;
         d_in   = cmd.num;
         q_in   = '0;
      end else if (run_ff) begin
         if (mul_ff) begin
            p_in = p_next;
            b_in = {b_ff[13:0], 2'b00};
         end else begin
            r_in = fits ? diff[23:0] : trial[23:0];
            d_in = {d_ff[23:0], 1'b0};
            q_in = {q_ff[14:0], fits};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         mul_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         mul_ff  <= mul_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
      den_ff <= den_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;
   assign rsp.rem  = r_ff;
   assign rsp.prod = p_rnd[30:15];

endmodule

/* src/count_in_click_generator_top.sv */
// ----------------------------------------------------------------------------
// count_in_click_generator_top: count-in metronome click mixed into audio
// One req beat is one audio sample (start request and mix sample); one rsp
// beat comes back for each: the mix with the click added and saturated, the
// click alone, and a done flag on the last sample of the count-in.
// Registers are to be written on the csr channel (index, data) only while no
// sample is in flight (left to the user). csr_ready is always high.
// Samples are handled one at a time. The work is done on the shared
// bit-serial unit: a 16-bit envelope divide and four radix-4 multiplies for
// a sample inside a click and, on a beat, two 24/25-bit remainder passes for
// the bar position first.
// req_ready is high only while no sample is being worked on. A finished
// result is held in the rsp registers; if the receiver stalls, the block
// holds the next result until the previous beat is taken.
// Reset loads the register defaults and leaves the count-in idle.
// ----------------------------------------------------------------------------
module count_in_click_generator_top #(
   parameter int SAMPLE_BITS      = 16,
   parameter int PHASE_BITS       = 16,
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int COUNT_BITS       = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_start_req,
   input  logic signed [SAMPLE_BITS-1:0]       req_mix_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_mix_out,
   output logic signed [SAMPLE_BITS-1:0]       rsp_click_sample,
   output logic                                rsp_count_done,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_index,
   input  logic [cicg_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam int SUM_W = (COUNT_BITS > 20 ? COUNT_BITS : 20) + 1;
   localparam int CW    = (SAMPLE_BITS > 17 ? SAMPLE_BITS : 17) + 1;
   localparam logic signed [CW-1:0] CLK_MAX = $signed(CW'({(SAMPLE_BITS-1){1'b1}}));
   localparam logic signed [CW-1:0] CLK_MIN = ~CLK_MAX;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_CHECK = 11'b00000000010,
      S_MOD1  = 11'b00000000100,
      S_MOD2  = 11'b00000001000,
      S_CLK   = 11'b00000010000,
      S_DIV   = 11'b00000100000,
      S_SQ    = 11'b00001000000,
      S_GAIN  = 11'b00010000000,
      S_ENV   = 11'b00100000000,
      S_TONE  = 11'b01000000000,
      S_FIN   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [19:0] beat_ff, beat_in;
   logic [23:0] bar_ff, bar_in;
   logic [23:0] total_ff, total_in;
   logic [15:0] gain_ff, gain_in;
   logic [15:0] long_ff, long_in;
   logic [15:0] short_ff, short_in;
   logic [15:0] hstep_ff, hstep_in;
   logic [15:0] lstep_ff, lstep_in;

   // count-in state
   logic [COUNT_BITS-1:0] left_ff, left_in;
   logic [COUNT_BITS-1:0] nba_ff, nba_in;
   logic [23:0]           nbib_ff, nbib_in;
   logic [15:0]           clen_ff, clen_in;
   logic [15:0]           crem_ff, crem_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] step_ff, step_in;
   logic                  accent_ff, accent_in;

   // per-sample datapath
   logic signed [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic signed [SAMPLE_BITS-1:0] click_ff, click_in;
   logic [15:0]                   env2_ff, env2_in;
   logic signed [15:0]            sine_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_mix_ff, rsp_mix_in;
   logic signed [SAMPLE_BITS-1:0] rsp_click_ff, rsp_click_in;
   logic                          rsp_done_ff, rsp_done_in;

   cicg_pkg::ser_cmd_type ser_cmd;
   cicg_pkg::ser_rsp_type ser_rsp;

   logic [19:0]           beat_eff;
   logic [23:0]           bar_eff;
   logic [COUNT_BITS-1:0] elapsed;
   logic [SUM_W-1:0]      nba_sum;
   logic [COUNT_BITS-1:0] nba_sat;
   logic                  down;
   logic [24:0]           mod2_num;
   logic [15:0]           rem_clamp;
   logic [15:0]           s_abs;
   logic [15:0]           amp;
   logic signed [CW-1:0]  mag_w;
   logic signed [CW-1:0]  click_wide;
   logic [SAMPLE_BITS-1:0] click_sat;
   logic [SAMPLE_BITS:0]   mix_sum;
   logic [SAMPLE_BITS-1:0] mix_sat;

   logic signed [15:0]                 sine_rom [SINE_TABLE_DEPTH];
   logic [PHASE_BITS+IDX_W-1:0]        phase_ext;
   logic [IDX_W-1:0]                   sine_idx;

   for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [63:0] ANG = (64'(gi) << 32) / SINE_TABLE_DEPTH;
      assign sine_rom[gi] = cicg_pkg::sine_q15(ANG);
   end

   assign phase_ext = {phase_ff, {IDX_W{1'b0}}};
   assign sine_idx  = phase_ext[PHASE_BITS +: IDX_W];

   always_ff @(posedge clock) begin
      sine_ff <= sine_rom[sine_idx];
   end

   cicg_serial u_serial (
      .clock (clock),
      .reset (reset),
      .cmd   (ser_cmd),
      .rsp   (ser_rsp)
   );

   assign beat_eff  = (beat_ff == 20'd0) ? 20'd1 : beat_ff;
   assign bar_eff   = (bar_ff == 24'd0) ? {2'b00, beat_eff, 2'b00} : bar_ff;
   assign elapsed   = COUNT_BITS'(total_ff) - left_ff;
   assign nba_sum   = SUM_W'(nba_ff) + SUM_W'(beat_eff);
   assign nba_sat   = (nba_sum > SUM_W'({COUNT_BITS{1'b1}})) ? '1 : nba_sum[COUNT_BITS-1:0];
   assign down      = {ser_rsp.rem, 1'b0} < {5'd0, beat_eff};
   assign mod2_num  = {1'b0, ser_rsp.rem} + {5'd0, beat_eff};
   assign rem_clamp = (crem_ff > clen_ff) ? clen_ff : crem_ff;
   assign s_abs     = sine_ff[15] ? 16'(16'sd0 - sine_ff) : sine_ff;
   assign amp       = accent_ff ? cicg_pkg::AMP_DOWN : cicg_pkg::AMP_OFF;

   assign mag_w      = $signed(CW'(ser_rsp.prod));
   assign click_wide = sine_ff[15] ? -mag_w : mag_w;
   assign click_sat  = (click_wide > CLK_MAX) ? CLK_MAX[SAMPLE_BITS-1:0] :
                       (click_wide < CLK_MIN) ? CLK_MIN[SAMPLE_BITS-1:0] :
                       click_wide[SAMPLE_BITS-1:0];

   assign mix_sum = {smp_ff[SAMPLE_BITS-1], smp_ff} + {click_ff[SAMPLE_BITS-1], click_ff};
   assign mix_sat = (mix_sum[SAMPLE_BITS] != mix_sum[SAMPLE_BITS-1]) ?
                    (mix_sum[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                          : {1'b0, {(SAMPLE_BITS-1){1'b1}}}) :
                    mix_sum[SAMPLE_BITS-1:0];

   // configuration writes
   always_comb begin
      beat_in  = beat_ff;
      bar_in   = bar_ff;
      total_in = total_ff;
      gain_in  = gain_ff;
      long_in  = long_ff;
      short_in = short_ff;
      hstep_in = hstep_ff;
      lstep_in = lstep_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cicg_pkg::CSR_BEAT_SAMPLES:    beat_in  = csr_data[19:0];
            cicg_pkg::CSR_BAR_SAMPLES:     bar_in   = csr_data[23:0];
            cicg_pkg::CSR_TOTAL_SAMPLES:   total_in = csr_data[23:0];
            cicg_pkg::CSR_CLICK_GAIN:      gain_in  = csr_data[15:0];
            cicg_pkg::CSR_LONG_CLICK_LEN:  long_in  = csr_data[15:0];
            cicg_pkg::CSR_SHORT_CLICK_LEN: short_in = csr_data[15:0];
            cicg_pkg::CSR_HIGH_PHASE_STEP: hstep_in = csr_data[15:0];
            cicg_pkg::CSR_LOW_PHASE_STEP:  lstep_in = csr_data[15:0];
         endcase
      end
   end

   // sample sequencer
   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      nba_in       = nba_ff;
      nbib_in      = nbib_ff;
      clen_in      = clen_ff;
      crem_in      = crem_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      accent_in    = accent_ff;
      smp_in       = smp_ff;
      click_in     = click_ff;
      env2_in      = env2_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_mix_in   = rsp_mix_ff;
      rsp_click_in = rsp_click_ff;
      rsp_done_in  = rsp_done_ff;
      ser_cmd      = '0;
      ser_cmd.op   = cicg_pkg::OP_MUL;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               smp_in = req_mix_in;
               if (req_start_req) begin
                  left_in  = COUNT_BITS'(total_ff);
                  nba_in   = '0;
                  nbib_in  = '0;
                  crem_in  = '0;
                  phase_in = '0;
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (left_ff == '0) begin
               click_in = '0;
               state_in = S_FIN;
            end else if (elapsed >= nba_ff) begin
               ser_cmd.go    = 1'b1;
               ser_cmd.op    = cicg_pkg::OP_DIV;
               ser_cmd.num   = {nbib_ff, 1'b0};
               ser_cmd.den   = bar_eff;
               ser_cmd.steps = cicg_pkg::MOD1_STEPS;
               state_in      = S_MOD1;
            end else begin
               state_in = S_CLK;
            end
         end
         S_MOD1: begin
            if (ser_rsp.done) begin
               accent_in     = down;
               clen_in       = down ? long_ff : short_ff;
               crem_in       = down ? long_ff : short_ff;
               phase_in      = '0;
               step_in       = down ? PHASE_BITS'(hstep_ff) : PHASE_BITS'(lstep_ff);
               nba_in        = nba_sat;
               ser_cmd.go    = 1'b1;
               ser_cmd.op    = cicg_pkg::OP_DIV;
               ser_cmd.num   = mod2_num;
               ser_cmd.den   = bar_eff;
               ser_cmd.steps = cicg_pkg::MOD2_STEPS;
               state_in      = S_MOD2;
            end
         end
         S_MOD2: begin
            if (ser_rsp.done) begin
               nbib_in  = ser_rsp.rem;
               state_in = S_CLK;
            end
         end
         S_CLK: begin
            if (crem_ff != 16'd0 && clen_ff != 16'd0) begin
               ser_cmd.go       = 1'b1;
               ser_cmd.op       = cicg_pkg::OP_DIV;
               ser_cmd.num      = {rem_clamp[0], 24'd0};
               ser_cmd.den      = {8'd0, clen_ff};
               ser_cmd.rem_init = {9'd0, rem_clamp[15:1]};
               ser_cmd.steps    = cicg_pkg::ENV_STEPS;
               state_in         = S_DIV;
            end else begin
               crem_in  = '0;
               click_in = '0;
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            if (ser_rsp.done) begin
               ser_cmd.go     = 1'b1;
               ser_cmd.mcand  = ser_rsp.quot;
               ser_cmd.mplier = ser_rsp.quot;
               state_in       = S_SQ;
            end
         end
         S_SQ: begin
            if (ser_rsp.done) begin
               env2_in        = ser_rsp.prod;
               ser_cmd.go     = 1'b1;
               ser_cmd.mcand  = gain_ff;
               ser_cmd.mplier = amp;
               state_in       = S_GAIN;
            end
         end
         S_GAIN: begin
            if (ser_rsp.done) begin
               ser_cmd.go     = 1'b1;
               ser_cmd.mcand  = ser_rsp.prod;
               ser_cmd.mplier = env2_ff;
               state_in       = S_ENV;
            end
         end
         S_ENV: begin
            if (ser_rsp.done) begin
               ser_cmd.go     = 1'b1;
               ser_cmd.mcand  = ser_rsp.prod;
               ser_cmd.mplier = s_abs;
               state_in       = S_TONE;
            end
         end
         S_TONE: begin
            if (ser_rsp.done) begin
               click_in = click_sat;
               phase_in = phase_ff + step_ff;
               crem_in  = crem_ff - 16'd1;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_done_in = 1'b0;
               if (left_ff != '0) begin
                  left_in = left_ff - COUNT_BITS'(1);
                  if (left_ff == COUNT_BITS'(1)) begin
                     rsp_done_in = 1'b1;
                     crem_in     = '0;
                  end
               end
               rsp_mix_in   = mix_sat;
               rsp_click_in = click_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         beat_ff      <= cicg_pkg::BEAT_RST;
         bar_ff       <= cicg_pkg::BAR_RST;
         total_ff     <= cicg_pkg::TOTAL_RST;
         gain_ff      <= cicg_pkg::GAIN_RST;
         long_ff      <= cicg_pkg::LONG_RST;
         short_ff     <= cicg_pkg::SHORT_RST;
         hstep_ff     <= cicg_pkg::HSTEP_RST;
         lstep_ff     <= cicg_pkg::LSTEP_RST;
         left_ff      <= '0;
         nba_ff       <= '0;
         nbib_ff      <= '0;
         clen_ff      <= 16'd1;
         crem_ff      <= '0;
         phase_ff     <= '0;
         step_ff      <= '0;
         accent_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         beat_ff      <= beat_in;
         bar_ff       <= bar_in;
         total_ff     <= total_in;
         gain_ff      <= gain_in;
         long_ff      <= long_in;
         short_ff     <= short_in;
         hstep_ff     <= hstep_in;
         lstep_ff     <= lstep_in;
         left_ff      <= left_in;
         nba_ff       <= nba_in;
         nbib_ff      <= nbib_in;
         clen_ff      <= clen_in;
         crem_ff      <= crem_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         accent_ff    <= accent_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff       <= smp_in;
      click_ff     <= click_in;
      env2_ff      <= env2_in;
      rsp_mix_ff   <= rsp_mix_in;
      rsp_click_ff <= rsp_click_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mix_out      = rsp_mix_ff;
   assign rsp_click_sample = rsp_click_ff;
   assign rsp_count_done   = rsp_done_ff;

endmodule
